### hdl/arm_inertia_gravity_torque_macros.svh
// Assertion macros shared by the arm inertia and gravity torque RTL.
`ifndef ARM_INERTIA_GRAVITY_TORQUE_MACROS_SVH
`define ARM_INERTIA_GRAVITY_TORQUE_MACROS_SVH

// Check cons in the same cycle as ante, ignored while reset is low.
`define AGT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check cons after ante, delayed by the dly argument.
`define AGT_ASSERT_LATER(label, ante, dly, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##dly (cons)) else $error(msg);

`endif

### hdl/agt_pkg.sv
// Shared types and pipeline constants for the arm inertia and gravity torque block.
package agt_pkg;

    // Q16 sine or cosine, -65536..65536
    typedef logic signed [17:0] t_trig;

    // all trig values one request needs
    typedef struct packed {
        t_trig c2;
        t_trig s2;
        t_trig c23;
        t_trig s23;
        t_trig c3;
        t_trig s3;
        t_trig c1;
        t_trig c12;
        t_trig c123;
    } t_trig_set;

    // unpacked view of the configuration registers
    typedef struct packed {
        logic [2:0][19:0]  len;
        logic [4:0][11:0]  mass;
        logic [9:0][15:0]  inertia;
        logic [15:0]       grav;
    } t_cfg;

    localparam int SINE_STAGES = 7;
    localparam int DYN_STAGES  = 7;

endpackage

### hdl/agt_sine.sv
// Pipelined Q16 sine of a 32-bit phase: quadrant fold and degree-9 Horner polynomial.
module agt_sine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [31:0]   i_phase,
    output logic          o_valid,
    output agt_pkg::t_trig o_value
);

    localparam logic [30:0] K1 = 31'd1686629713;
    localparam logic [30:0] K3 = 31'd693598668;
    localparam logic [30:0] K5 = 31'd85569306;
    localparam logic [30:0] K7 = 31'd5026994;
    localparam logic [30:0] K9 = 31'd172273;
    localparam logic [30:0] QTR_ONE = 31'h40000000;

    logic [6:0]      r_v;
    logic [30:0]     r_x   [0:5];
    logic [5:0]      r_neg;
    logic [30:0]     r_x2  [1:4];
    logic [30:0]     r_y   [2:5];
    agt_pkg::t_trig  r_out;

    logic [30:0]     n_x;
    logic [61:0]     w_sq;
    logic [30:0]     n_x2;
    logic [61:0]     w_hp  [0:3];
    logic [30:0]     n_y   [0:3];
    logic [30:0]     w_hk  [0:3];
    logic [61:0]     w_fp;
    logic [31:0]     w_rs;
    logic [17:0]     w_rr;
    logic [16:0]     w_mag;
    agt_pkg::t_trig  n_out;

    always_comb begin
        // fold odd quadrants onto the rising quarter
        n_x  = i_phase[30] ? (QTR_ONE - {1'b0, i_phase[29:0]}) : {1'b0, i_phase[29:0]};
        w_sq = 62'(r_x[0]) * 62'(r_x[0]);
        n_x2 = w_sq[60:30];

        w_hk[0] = K7;
        w_hk[1] = K5;
        w_hk[2] = K3;
        w_hk[3] = K1;
        w_hp[0] = 62'(K9) * 62'(r_x2[1]);
        for (int j = 1; j < 4; j++) begin
            w_hp[j] = 62'(r_y[j + 1]) * 62'(r_x2[j + 1]);
        end
        for (int j = 0; j < 4; j++) begin
            n_y[j] = w_hk[j] - w_hp[j][60:30];
        end

        w_fp  = 62'(r_y[5]) * 62'(r_x[5]);
        w_rs  = w_fp[61:30] + 32'd8192;
        w_rr  = w_rs[31:14];
        w_mag = (w_rr > 18'd65536) ? 17'h10000 : w_rr[16:0];
        n_out = r_neg[5] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]   <= n_x;
        r_neg[0] <= i_phase[31];
        for (int s = 1; s < 6; s++) begin
            r_x[s]   <= r_x[s - 1];
            r_neg[s] <= r_neg[s - 1];
        end
        r_x2[1] <= n_x2;
        for (int s = 2; s < 5; s++) begin
            r_x2[s] <= r_x2[s - 1];
        end
        for (int j = 0; j < 4; j++) begin
            r_y[j + 2] <= n_y[j];
        end
        r_out <= n_out;
    end

    assign o_valid = r_v[6];
    assign o_value = r_out;

endmodule

### hdl/agt_dyn.sv
// Link geometry, mass sums, moment rounding and gravity torque pipeline.
module agt_dyn (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  agt_pkg::t_trig_set i_trig,
    input  agt_pkg::t_cfg      i_cfg,
    output logic               o_valid,
    output logic [31:0]        o_moment_base,
    output logic [31:0]        o_moment_shoulder,
    output logic [31:0]        o_moment_elbow,
    output logic [31:0]        o_moment_wrist,
    output logic signed [31:0] o_torque_shoulder,
    output logic signed [31:0] o_torque_elbow,
    output logic signed [31:0] o_torque_wrist
);

    // len * trig rounded to 2^-16, half away from zero
    function automatic logic signed [23:0] lc(input logic signed [21:0] len,
                                              input logic signed [17:0] trig);
        logic signed [39:0] p;
        logic [39:0]        mag;
        logic [39:0]        q;
        p   = 40'(len) * 40'(trig);
        mag = p[39] ? -p : p;
        q   = (mag + 40'd32768) >> 16;
        return p[39] ? -$signed(q[23:0]) : $signed(q[23:0]);
    endfunction

    function automatic logic signed [40:0] rnd18(input logic signed [58:0] v);
        logic [58:0] mag;
        logic [58:0] q;
        mag = v[58] ? -v : v;
        q   = (mag + 59'd131072) >> 18;
        return v[58] ? -$signed(q[40:0]) : $signed(q[40:0]);
    endfunction

    function automatic logic signed [31:0] rnd22_sat(input logic signed [57:0] v);
        logic [57:0]        mag;
        logic [57:0]        q;
        logic signed [36:0] r;
        mag = v[57] ? -v : v;
        q   = (mag + 58'd2097152) >> 22;
        r   = v[57] ? -$signed(q[36:0]) : $signed(q[36:0]);
        if (r > 37'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (r < -37'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return r[31:0];
        end
    endfunction

    function automatic logic [31:0] moment_out(input logic [18:0] isum,
                                               input logic [63:0] mass);
        logic [63:0] t;
        t = 64'({isum, 26'd0}) + mass;
        t = t + 64'd33554432;
        t = t >> 26;
        return (|t[63:32]) ? 32'hFFFFFFFF : t[31:0];
    endfunction

    logic [19:0] w_l0, w_l1, w_l2;
    logic [11:0] w_m0, w_m1, w_m2, w_m3, w_m4;
    logic [16:0] w_ms_a;
    logic [16:0] w_ms_b;
    logic [18:0] w_is_base, w_is_shoulder, w_is_elbow, w_is_wrist;

    logic [6:0]         r_v;
    logic signed [23:0] r1_lc [0:7];
    logic signed [38:0] r1_pa, r1_pb, r1_pd;
    logic signed [25:0] r2_cp [0:7];
    logic signed [56:0] r2_ta, r2_tb, r2_td;
    logic [51:0]        r3_sq [0:7];
    logic signed [58:0] r3_t  [0:2];
    logic [52:0]        r4_bq [0:3];
    logic [39:0]        r4_lq [0:2];
    logic signed [40:0] r4_r  [0:2];
    logic [63:0]        r5_mp [0:8];
    logic signed [57:0] r5_tg [0:2];
    logic [63:0]        r6_shared, r6_elbow, r6_wrist;
    logic signed [31:0] r6_tq [0:2];
    logic [31:0]        r7_mb, r7_ms, r7_me, r7_mw;
    logic signed [31:0] r7_tq [0:2];

    logic signed [25:0] w_2l0;
    logic signed [25:0] w_2l1;
    logic signed [51:0] w_sqp [0:7];

    always_comb begin
        w_l0 = i_cfg.len[0];
        w_l1 = i_cfg.len[1];
        w_l2 = i_cfg.len[2];
        w_m0 = i_cfg.mass[0];
        w_m1 = i_cfg.mass[1];
        w_m2 = i_cfg.mass[2];
        w_m3 = i_cfg.mass[3];
        w_m4 = i_cfg.mass[4];
        // torque mass weights: pa and pb each carry one combined mass, pd carries m4 alone
        w_ms_a = 17'(w_m0) + {4'd0, w_m1, 1'b0} + {4'd0, w_m2, 1'b0}
               + {4'd0, w_m3, 1'b0} + {4'd0, w_m4, 1'b0};
        w_ms_b = 17'(w_m2) + {4'd0, w_m3, 1'b0} + {4'd0, w_m4, 1'b0};
        w_is_base     = 19'(i_cfg.inertia[0]) + 19'(i_cfg.inertia[1])
                      + 19'(i_cfg.inertia[2]) + 19'(i_cfg.inertia[3])
                      + 19'(i_cfg.inertia[4]);
        w_is_shoulder = 19'(i_cfg.inertia[5]) + 19'(i_cfg.inertia[6])
                      + 19'(i_cfg.inertia[7]) + 19'(i_cfg.inertia[8])
                      + 19'(i_cfg.inertia[9]);
        w_is_elbow    = 19'(i_cfg.inertia[7]) + 19'(i_cfg.inertia[8])
                      + 19'(i_cfg.inertia[9]);
        w_is_wrist    = 19'(i_cfg.inertia[9]);
        w_2l0 = $signed({5'd0, w_l0, 1'b0});
        w_2l1 = $signed({5'd0, w_l1, 1'b0});
        for (int k = 0; k < 8; k++) begin
            w_sqp[k] = 52'(r2_cp[k]) * 52'(r2_cp[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: rounded distance components and raw link moments
        r1_lc[0] <= lc({2'd0, w_l1}, $signed(i_trig.c2));
        r1_lc[1] <= lc({2'd0, w_l1}, $signed(i_trig.s2));
        r1_lc[2] <= lc({1'b0, w_l1, 1'b0}, $signed(i_trig.c2));
        r1_lc[3] <= lc({1'b0, w_l1, 1'b0}, $signed(i_trig.s2));
        r1_lc[4] <= lc({2'd0, w_l2}, $signed(i_trig.c23));
        r1_lc[5] <= lc({2'd0, w_l2}, $signed(i_trig.s23));
        r1_lc[6] <= lc({2'd0, w_l2}, $signed(i_trig.c3));
        r1_lc[7] <= lc({2'd0, w_l2}, $signed(i_trig.s3));
        r1_pa <= 39'($signed({1'b0, w_l0})) * 39'($signed(i_trig.c1));
        r1_pb <= 39'($signed({1'b0, w_l1})) * 39'($signed(i_trig.c12));
        r1_pd <= 39'($signed({1'b0, w_l2})) * 39'($signed(i_trig.c123));

        // stage 2: x and y of each squared distance; link moments times mass weights
        r2_cp[0] <= w_2l0 + 26'(r1_lc[0]);
        r2_cp[1] <= 26'(r1_lc[1]);
        r2_cp[2] <= w_2l0 + 26'(r1_lc[2]);
        r2_cp[3] <= 26'(r1_lc[3]);
        r2_cp[4] <= w_2l0 + 26'(r1_lc[2]) + 26'(r1_lc[4]);
        r2_cp[5] <= 26'(r1_lc[3]) + 26'(r1_lc[5]);
        r2_cp[6] <= w_2l1 + 26'(r1_lc[6]);
        r2_cp[7] <= 26'(r1_lc[7]);
        r2_ta <= 57'(r1_pa) * 57'($signed({1'b0, w_ms_a}));
        r2_tb <= 57'(r1_pb) * 57'($signed({1'b0, w_ms_b}));
        r2_td <= 57'(r1_pd) * 57'($signed({1'b0, w_m4}));

        // stage 3: squares and mass-moment sums
        for (int k = 0; k < 8; k++) begin
            r3_sq[k] <= w_sqp[k];
        end
        r3_t[0] <= 59'(r2_ta) + 59'(r2_tb) + 59'(r2_td);
        r3_t[1] <= 59'(r2_tb) + 59'(r2_td);
        r3_t[2] <= 59'(r2_td);

        // stage 4: x^2 + y^2, link length squares, first torque rounding
        for (int k = 0; k < 4; k++) begin
            r4_bq[k] <= 53'(r3_sq[2 * k]) + 53'(r3_sq[2 * k + 1]);
        end
        r4_lq[0] <= 40'(w_l0) * 40'(w_l0);
        r4_lq[1] <= 40'(w_l1) * 40'(w_l1);
        r4_lq[2] <= 40'(w_l2) * 40'(w_l2);
        for (int k = 0; k < 3; k++) begin
            r4_r[k] <= rnd18(r3_t[k]);
        end

        // stage 5: mass products, wrapping in 64 bits; torque times g
        r5_mp[0] <= 64'(w_m0) * 64'(r4_lq[0]);
        r5_mp[1] <= (64'(w_m1) * 64'(r4_lq[0])) << 2;
        r5_mp[2] <= 64'(w_m2) * 64'(r4_bq[0]);
        r5_mp[3] <= 64'(w_m3) * 64'(r4_bq[1]);
        r5_mp[4] <= 64'(w_m4) * 64'(r4_bq[2]);
        r5_mp[5] <= 64'(w_m2) * 64'(r4_lq[1]);
        r5_mp[6] <= (64'(w_m3) * 64'(r4_lq[1])) << 2;
        r5_mp[7] <= 64'(w_m4) * 64'(r4_bq[3]);
        r5_mp[8] <= 64'(w_m4) * 64'(r4_lq[2]);
        for (int k = 0; k < 3; k++) begin
            r5_tg[k] <= 58'(r4_r[k]) * 58'($signed({1'b0, i_cfg.grav}));
        end

        // stage 6: mass sums; torque to 2^-8 with clamp
        r6_shared <= r5_mp[0] + r5_mp[1] + r5_mp[2] + r5_mp[3] + r5_mp[4];
        r6_elbow  <= r5_mp[5] + r5_mp[6] + r5_mp[7];
        r6_wrist  <= r5_mp[8];
        for (int k = 0; k < 3; k++) begin
            r6_tq[k] <= rnd22_sat(r5_tg[k]);
        end

        // stage 7: add inertia terms, round and clamp moments
        r7_mb <= moment_out(w_is_base, r6_shared);
        r7_ms <= moment_out(w_is_shoulder, r6_shared);
        r7_me <= moment_out(w_is_elbow, r6_elbow);
        r7_mw <= moment_out(w_is_wrist, r6_wrist);
        for (int k = 0; k < 3; k++) begin
            r7_tq[k] <= r6_tq[k];
        end
    end

    assign o_valid           = r_v[6];
    assign o_moment_base     = r7_mb;
    assign o_moment_shoulder = r7_ms;
    assign o_moment_elbow    = r7_me;
    assign o_moment_wrist    = r7_mw;
    assign o_torque_shoulder = r7_tq[0];
    assign o_torque_elbow    = r7_tq[1];
    assign o_torque_wrist    = r7_tq[2];

endmodule

### hdl/arm_inertia_gravity_torque.sv
// A request is registered into the phase stage, then passes through the sine and dynamics stages to the result strobe.
// Throughput: one request per cycle while busy is low; a 15-stage pipeline (1 phase, 7 sine, 7 dynamics).
// Nine sine pipelines run in parallel; busy is high only while reset is held.
// Reset is synchronous, active low: it clears the pipeline valids and loads default config.
// Results are shown for one cycle with o_result_valid; the receiver cannot stall them.
`include "arm_inertia_gravity_torque_macros.svh"

module arm_inertia_gravity_torque #(
    parameter int ANGLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_joint_one_angle,
    input  logic signed [15:0] i_joint_two_angle,
    input  logic signed [15:0] i_joint_three_angle,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    output logic               o_result_valid,
    output logic [31:0]        o_moment_base,
    output logic [31:0]        o_moment_shoulder,
    output logic [31:0]        o_moment_elbow,
    output logic [31:0]        o_moment_wrist,
    output logic signed [31:0] o_torque_shoulder,
    output logic signed [31:0] o_torque_elbow,
    output logic signed [31:0] o_torque_wrist
);

    // configuration register indexes
    localparam logic [2:0] REG_LINK_LENGTHS = 3'd0;
    localparam logic [2:0] REG_LINK_MASSES  = 3'd1;
    localparam logic [2:0] REG_INERTIA_A    = 3'd2;
    localparam logic [2:0] REG_INERTIA_B    = 3'd3;
    localparam logic [2:0] REG_INERTIA_C    = 3'd4;
    localparam logic [2:0] REG_GRAVITY      = 3'd5;

    localparam logic [15:0] GRAV_RESET = 16'd10045;
    localparam logic [31:0] QTR_TURN   = 32'h40000000;
    localparam int          N_TRIG     = 9;
    localparam int          TRIG_LAT   = agt_pkg::SINE_STAGES + agt_pkg::DYN_STAGES;
    localparam int          RES_LAT    = 1 + TRIG_LAT;

    // sign-extend, keep one turn of ANGLE_BITS and scale to a 32-bit phase
    function automatic logic [31:0] to_phase(input logic [15:0] a);
        logic [31:0] ext;
        ext = {{16{a[15]}}, a};
        return ext << (32 - ANGLE_BITS);
    endfunction

    logic [59:0] r_len;
    logic [59:0] r_mass;
    logic [63:0] r_ia;
    logic [63:0] r_ib;
    logic [31:0] r_ic;
    logic [15:0] r_g;

    logic        w_take;
    logic [31:0] w_p1, w_p2, w_p3, w_p12, w_p23, w_p123;
    logic [31:0] n_ph [0:N_TRIG-1];
    logic [31:0] r_ph [0:N_TRIG-1];
    logic        r_ph_v;

    logic [N_TRIG-1:0]  w_sin_v;
    agt_pkg::t_trig     w_sin [0:N_TRIG-1];
    agt_pkg::t_trig_set w_trig;
    agt_pkg::t_cfg      w_cfg;

    // a request is refused only while reset is held
    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign w_take      = start & ~busy;

    // configuration: bits above each register's width drop, unknown index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_mass <= '0;
            r_ia   <= '0;
            r_ib   <= '0;
            r_ic   <= '0;
            r_g    <= GRAV_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LINK_LENGTHS: begin
                    r_len <= i_cfg_data[59:0];
                end
                REG_LINK_MASSES: begin
                    r_mass <= i_cfg_data[59:0];
                end
                REG_INERTIA_A: begin
                    r_ia <= i_cfg_data;
                end
                REG_INERTIA_B: begin
                    r_ib <= i_cfg_data;
                end
                REG_INERTIA_C: begin
                    r_ic <= i_cfg_data[31:0];
                end
                REG_GRAVITY: begin
                    r_g <= i_cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    // phases for every sine and cosine; sums wrap over a full turn,
    // a cosine is the sine a quarter turn on
    always_comb begin
        w_p1   = to_phase(i_joint_one_angle);
        w_p2   = to_phase(i_joint_two_angle);
        w_p3   = to_phase(i_joint_three_angle);
        w_p12  = w_p1 + w_p2;
        w_p23  = w_p2 + w_p3;
        w_p123 = w_p12 + w_p3;
        n_ph[0] = w_p2 + QTR_TURN;
        n_ph[1] = w_p2;
        n_ph[2] = w_p23 + QTR_TURN;
        n_ph[3] = w_p23;
        n_ph[4] = w_p3 + QTR_TURN;
        n_ph[5] = w_p3;
        n_ph[6] = w_p1 + QTR_TURN;
        n_ph[7] = w_p12 + QTR_TURN;
        n_ph[8] = w_p123 + QTR_TURN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_v <= 1'b0;
        end else begin
            r_ph_v <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N_TRIG; k++) begin
            r_ph[k] <= n_ph[k];
        end
    end

    // nine sine pipelines in lock step
    for (genvar gi = 0; gi < N_TRIG; gi++) begin : g_sine
        agt_sine u_sine (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_ph_v),
            .i_phase (r_ph[gi]),
            .o_valid (w_sin_v[gi]),
            .o_value (w_sin[gi])
        );
    end

    always_comb begin
        w_trig.c2   = w_sin[0];
        w_trig.s2   = w_sin[1];
        w_trig.c23  = w_sin[2];
        w_trig.s23  = w_sin[3];
        w_trig.c3   = w_sin[4];
        w_trig.s3   = w_sin[5];
        w_trig.c1   = w_sin[6];
        w_trig.c12  = w_sin[7];
        w_trig.c123 = w_sin[8];
        w_cfg.len     = r_len;
        w_cfg.mass    = r_mass;
        w_cfg.inertia = {r_ic, r_ib, r_ia};
        w_cfg.grav    = r_g;
    end

    // geometry, mass sums, rounding and clamps; last stage holds the result
    agt_dyn u_dyn (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_sin_v[0]),
        .i_trig            (w_trig),
        .i_cfg             (w_cfg),
        .o_valid           (o_result_valid),
        .o_moment_base     (o_moment_base),
        .o_moment_shoulder (o_moment_shoulder),
        .o_moment_elbow    (o_moment_elbow),
        .o_moment_wrist    (o_moment_wrist),
        .o_torque_shoulder (o_torque_shoulder),
        .o_torque_elbow    (o_torque_elbow),
        .o_torque_wrist    (o_torque_wrist)
    );

    `AGT_ASSERT_SAME(a_result_has_request, o_result_valid, $past(w_take, RES_LAT), "result strobe without a matching request")
    `AGT_ASSERT_SAME(a_sine_lock_step, w_sin_v[0], &w_sin_v, "sine pipelines out of step")
    `AGT_ASSERT_LATER(a_request_gives_result, r_ph_v, TRIG_LAT, o_result_valid, "request lost in pipeline")

endmodule
